// File: hw/rtl/assert_macros.svh
// Assertion macros used by the route table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hw/rtl/rtmp_pkg.sv
// Types and constants of the route table unit.
`default_nettype none
package rtmp_pkg;
    localparam int unsigned RESULT_CAP = 32;
    localparam int unsigned CNT_W      = 6;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_DEL  = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    localparam logic [1:0] AGE_GOOD = 2'd0;
    localparam logic [1:0] AGE_SUSP = 2'd1;
    localparam logic [1:0] AGE_BAD  = 2'd2;
    localparam logic [1:0] AGE_BAD2 = 2'd3;

    localparam logic [4:0] DIST_MASKED = 5'd31;
    localparam logic [4:0] DIST_LIMIT  = 5'd15;
    localparam logic [5:0] HOPS_DEAD   = 6'd16;
    localparam int unsigned EXT_BIT    = 7;

    typedef struct packed {
        logic [15:0] rt_start;
        logic [15:0] rt_end;
        logic [5:0]  hops;
        logic [15:0] rnet;
        logic [7:0]  rnode;
        logic [1:0]  age;
        logic        ext;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] rt_start;
        logic [15:0] rt_end;
        logic [15:0] rnet;
        logic [7:0]  rnode;
        logic        done;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

// File: hw/rtl/rtmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rtmp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/rtmp_route_table_unit.sv
// Route table unit: range lookup, update and aging over a slot RAM.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | opcode, range, tuple info, router
//  output  | out       | o_out_valid / i_out_ready  | notify kind, range, router, flags
//
// One input transaction walks every slot through the single RAM read port,
// one slot per cycle unless stalled, for an update and for a tick alike.
// Any walk stalls while an earlier result waits on the output.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// A new transaction is taken only when the previous one has finished its walk.
`default_nettype none
`include "assert_macros.svh"
module rtmp_route_table_unit #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_range_start,
    input  wire logic [15:0] i_range_end,
    input  wire logic [7:0]  i_tuple_info,
    input  wire logic [15:0] i_router_net,
    input  wire logic [7:0]  i_router_node,
    input  wire logic        i_final_tuple,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_notify_kind,
    output logic [15:0]      o_route_start,
    output logic [15:0]      o_route_end,
    output logic [15:0]      o_via_net,
    output logic [7:0]       o_via_node,
    output logic             o_packet_done,
    output logic             o_last
);
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned IW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [IW-1:0]                 r_idx, n_idx;
    logic                          r_pipe, n_pipe;
    logic [AW-1:0]                 r_pidx, n_pidx;
    logic [TABLE_ENTRIES-1:0]      r_valid, n_valid;
    logic                          r_op, n_op;
    logic [15:0]                   r_lo, n_lo;
    logic [15:0]                   r_hi, n_hi;
    logic [7:0]                    r_info, n_info;
    logic [15:0]                   r_rnet, n_rnet;
    logic [7:0]                    r_rnode, n_rnode;
    logic                          r_final, n_final;
    logic                          r_found, n_found;
    logic [AW-1:0]                 r_slot, n_slot;
    logic                          r_has_free, n_has_free;
    logic [AW-1:0]                 r_free, n_free;
    rtmp_pkg::t_entry              r_ent, n_ent;
    logic                          r_hp, n_hp;
    rtmp_pkg::t_result             r_held, n_held;
    logic [rtmp_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_ov, n_ov;
    rtmp_pkg::t_result             r_out, n_out;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    rtmp_pkg::t_entry              ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [rtmp_pkg::ENTRY_W-1:0]  ram_rdata;
    rtmp_pkg::t_entry              rd_ent;
    rtmp_pkg::t_entry              upd;
    logic [4:0]                    tup_dist;
    logic [5:0]                    hops_new;
    logic                          tup_ext;
    logic                          same;
    logic                          replace;

    assign ram_raddr = (r_idx < LAST_IDX) ? r_idx[AW-1:0] : '0;
    assign rd_ent    = rtmp_pkg::t_entry'(ram_rdata);

    rtmp_ram #(
        .WIDTH (rtmp_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign tup_dist = r_info[4:0];
    assign hops_new = {1'b0, tup_dist} + 6'd1;
    assign tup_ext  = r_info[rtmp_pkg::EXT_BIT];
    assign same     = (r_ent.rnet == r_rnet) && (r_ent.rnode == r_rnode);
    assign replace  = (tup_dist < rtmp_pkg::DIST_LIMIT) &&
                      ((r_ent.age == rtmp_pkg::AGE_BAD) || (r_ent.hops >= hops_new));

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_notify_kind = r_out.kind;
    assign o_route_start = r_out.rt_start;
    assign o_route_end   = r_out.rt_end;
    assign o_via_net     = r_out.rnet;
    assign o_via_node    = r_out.rnode;
    assign o_packet_done = r_out.done;
    assign o_last        = r_out.last;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pipe     = r_pipe;
        n_pidx     = r_pidx;
        n_valid    = r_valid;
        n_op       = r_op;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_info     = r_info;
        n_rnet     = r_rnet;
        n_rnode    = r_rnode;
        n_final    = r_final;
        n_found    = r_found;
        n_slot     = r_slot;
        n_has_free = r_has_free;
        n_free     = r_free;
        n_ent      = r_ent;
        n_hp       = r_hp;
        n_held     = r_held;
        n_cnt      = r_cnt;
        n_ov       = r_ov;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_pidx;
        ram_wdata  = rd_ent;
        upd        = r_ent;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_opcode;
                    n_lo       = i_range_start;
                    n_hi       = i_tuple_info[rtmp_pkg::EXT_BIT] ? i_range_end
                                                                 : i_range_start;
                    n_info     = i_tuple_info;
                    n_rnet     = i_router_net;
                    n_rnode    = i_router_node;
                    n_final    = i_final_tuple;
                    n_idx      = '0;
                    n_pipe     = 1'b0;
                    n_found    = 1'b0;
                    n_has_free = 1'b0;
                    n_hp       = 1'b0;
                    n_cnt      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ov) begin
                    // rewind so the pending slot is read again after the stall
                    n_pipe = 1'b0;
                    if (r_pipe) begin
                        n_idx = IW'(r_pidx);
                    end
                end else begin
                    if (r_idx < LAST_IDX) begin
                        n_idx  = r_idx + 1'b1;
                        n_pipe = 1'b1;
                        n_pidx = r_idx[AW-1:0];
                    end else begin
                        n_pipe = 1'b0;
                    end
                    if (r_pipe) begin
                        if (!r_op) begin
                            if (r_valid[r_pidx]) begin
                                if (!r_found && rd_ent.rt_start == r_lo &&
                                    rd_ent.rt_end == r_hi) begin
                                    n_found = 1'b1;
                                    n_slot  = r_pidx;
                                    n_ent   = rd_ent;
                                end
                            end else if (!r_has_free) begin
                                n_has_free = 1'b1;
                                n_free     = r_pidx;
                            end
                        end else if (r_valid[r_pidx]) begin
                            ram_we    = 1'b1;
                            ram_wdata = rd_ent;
                            case (rd_ent.age)
                                rtmp_pkg::AGE_GOOD: begin
                                    if (rd_ent.hops != 6'd0) begin
                                        ram_wdata.age = rtmp_pkg::AGE_SUSP;
                                    end
                                end
                                rtmp_pkg::AGE_SUSP: ram_wdata.age = rtmp_pkg::AGE_BAD;
                                rtmp_pkg::AGE_BAD:  ram_wdata.age = rtmp_pkg::AGE_BAD2;
                                default: begin
                                    ram_we           = 1'b0;
                                    n_valid[r_pidx]  = 1'b0;
                                    if (r_cnt < rtmp_pkg::CNT_W'(rtmp_pkg::RESULT_CAP)) begin
                                        n_cnt = r_cnt + 1'b1;
                                        if (r_hp) begin
                                            n_out      = r_held;
                                            n_out.last = 1'b0;
                                            n_ov       = 1'b1;
                                        end
                                        n_hp           = 1'b1;
                                        n_held.kind    = rtmp_pkg::KIND_DEL;
                                        n_held.rt_start = rd_ent.rt_start;
                                        n_held.rt_end  = rd_ent.rt_end;
                                        n_held.rnet    = rd_ent.rnet;
                                        n_held.rnode   = rd_ent.rnode;
                                        n_held.done    = 1'b0;
                                        n_held.last    = 1'b0;
                                    end
                                end
                            endcase
                        end
                    end else if (r_idx >= LAST_IDX) begin
                        n_state = r_op ? S_FINISH : S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (!r_ov) begin
                    n_ov       = 1'b1;
                    n_out      = '0;
                    n_out.done = r_final;
                    n_out.last = 1'b1;
                    n_state    = S_IDLE;
                    if (r_found) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_slot;
                        if (replace) begin
                            upd.hops  = hops_new;
                            upd.rnet  = r_rnet;
                            upd.rnode = r_rnode;
                            upd.age   = rtmp_pkg::AGE_GOOD;
                            if (!same) begin
                                n_out.kind = rtmp_pkg::KIND_ADD;
                            end
                        end else if (same) begin
                            if (tup_dist != rtmp_pkg::DIST_MASKED) begin
                                upd.hops = hops_new;
                                if (hops_new < rtmp_pkg::HOPS_DEAD) begin
                                    upd.age = rtmp_pkg::AGE_GOOD;
                                end else begin
                                    n_valid[r_slot] = 1'b0;
                                    n_out.kind      = rtmp_pkg::KIND_DEL;
                                end
                            end else begin
                                upd.age = rtmp_pkg::AGE_BAD;
                            end
                        end
                        if (tup_ext) begin
                            upd.ext = 1'b1;
                        end
                        ram_wdata = upd;
                        if (n_out.kind != rtmp_pkg::KIND_NONE) begin
                            n_out.rt_start = upd.rt_start;
                            n_out.rt_end   = upd.rt_end;
                            n_out.rnet     = upd.rnet;
                            n_out.rnode    = upd.rnode;
                        end
                    end else begin
                        n_out.kind     = r_has_free ? rtmp_pkg::KIND_ADD : rtmp_pkg::KIND_DROP;
                        n_out.rt_start = r_lo;
                        n_out.rt_end   = r_hi;
                        n_out.rnet     = r_rnet;
                        n_out.rnode    = r_rnode;
                        if (r_has_free) begin
                            ram_we          = 1'b1;
                            ram_waddr       = r_free;
                            ram_wdata.rt_start = r_lo;
                            ram_wdata.rt_end   = r_hi;
                            ram_wdata.hops  = hops_new;
                            ram_wdata.rnet  = r_rnet;
                            ram_wdata.rnode = r_rnode;
                            ram_wdata.age   = (tup_dist == rtmp_pkg::DIST_MASKED) ?
                                              rtmp_pkg::AGE_BAD : rtmp_pkg::AGE_GOOD;
                            ram_wdata.ext   = tup_ext;
                            n_valid[r_free] = 1'b1;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    if (r_hp) begin
                        n_out = r_held;
                    end else begin
                        n_out = '0;
                    end
                    n_out.done = 1'b0;
                    n_out.last = 1'b1;
                    n_hp       = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pipe  <= 1'b0;
            r_valid <= '0;
            r_found <= 1'b0;
            r_has_free <= 1'b0;
            r_hp    <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pipe  <= n_pipe;
            r_valid <= n_valid;
            r_found <= n_found;
            r_has_free <= n_has_free;
            r_hp    <= n_hp;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx  <= n_pidx;
        r_op    <= n_op;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_info  <= n_info;
        r_rnet  <= n_rnet;
        r_rnode <= n_rnode;
        r_final <= n_final;
        r_slot  <= n_slot;
        r_free  <= n_free;
        r_ent   <= n_ent;
        r_held  <= n_held;
        r_out   <= n_out;
    end

    `ASSERT_CLK(a_held_only_tick, i_clk, i_rst_n, r_hp |-> r_op)
    `ASSERT_CLK(a_cnt_capped, i_clk, i_rst_n, r_cnt <= rtmp_pkg::CNT_W'(rtmp_pkg::RESULT_CAP))
    `ASSERT_CLK(a_idle_no_held, i_clk, i_rst_n, o_in_ready |-> !r_hp)
    `ASSERT_CLK(a_pipe_in_scan, i_clk, i_rst_n, r_pipe |-> (r_state == S_SCAN))
    `ASSERT_NEVER(a_held_no_count, i_clk, i_rst_n, r_hp && (r_cnt == '0))
endmodule
`default_nettype wire

// File: tb/tb_rtmp_route_table_unit.sv
// Self-checking testbench for the route table unit: directed and random tuples and ticks.
`default_nettype none
module tb_rtmp_route_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic        op;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [7:0]  info;
        logic [15:0] rnet;
        logic [7:0]  rnode;
        logic        fin;
    } t_tuple;

    class route_scoreboard;
        rtmp_pkg::t_entry  tbl [SLOTS];
        bit                used [SLOTS];
        rtmp_pkg::t_result pending [$];
        int                errors;

        function new();
            errors = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function void push(logic [1:0] k, logic [15:0] s, logic [15:0] e,
                           logic [15:0] n, logic [7:0] d, logic fin);
            rtmp_pkg::t_result r;
            r.kind = k; r.rt_start = s; r.rt_end = e;
            r.rnet = n; r.rnode = d; r.done = fin; r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void note_update(t_tuple t);
            logic [4:0]  d;
            logic [5:0]  h;
            logic        ext, same;
            logic [15:0] hi;
            int slot, fr;
            d = t.info[4:0];
            h = {1'b0, d} + 6'd1;
            ext = t.info[rtmp_pkg::EXT_BIT];
            hi = ext ? t.hi : t.lo;
            slot = -1; fr = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i]) begin
                    if (slot < 0 && tbl[i].rt_start == t.lo && tbl[i].rt_end == hi) slot = i;
                end else if (fr < 0) fr = i;
            end
            if (slot >= 0) begin
                same = tbl[slot].rnet == t.rnet && tbl[slot].rnode == t.rnode;
                if ((tbl[slot].age == rtmp_pkg::AGE_BAD || tbl[slot].hops >= h) &&
                    d < rtmp_pkg::DIST_LIMIT) begin
                    tbl[slot].hops = h; tbl[slot].rnet = t.rnet;
                    tbl[slot].rnode = t.rnode; tbl[slot].age = rtmp_pkg::AGE_GOOD;
                    if (ext) tbl[slot].ext = 1'b1;
                    if (!same) begin
                        push(rtmp_pkg::KIND_ADD, tbl[slot].rt_start, tbl[slot].rt_end,
                             t.rnet, t.rnode, t.fin);
                        return;
                    end
                end else if (same) begin
                    if (d != rtmp_pkg::DIST_MASKED) begin
                        tbl[slot].hops = h;
                        if (h < rtmp_pkg::HOPS_DEAD) tbl[slot].age = rtmp_pkg::AGE_GOOD;
                        else begin
                            used[slot] = 0;
                            push(rtmp_pkg::KIND_DEL, tbl[slot].rt_start, tbl[slot].rt_end,
                                 tbl[slot].rnet, tbl[slot].rnode, t.fin);
                            return;
                        end
                    end else tbl[slot].age = rtmp_pkg::AGE_BAD;
                    if (ext) tbl[slot].ext = 1'b1;
                end else if (ext) tbl[slot].ext = 1'b1;
                push(rtmp_pkg::KIND_NONE, '0, '0, '0, '0, t.fin);
            end else if (fr < 0) begin
                push(rtmp_pkg::KIND_DROP, t.lo, hi, t.rnet, t.rnode, t.fin);
            end else begin
                used[fr] = 1;
                tbl[fr].rt_start = t.lo; tbl[fr].rt_end = hi; tbl[fr].hops = h;
                tbl[fr].rnet = t.rnet; tbl[fr].rnode = t.rnode; tbl[fr].ext = ext;
                tbl[fr].age = (d == rtmp_pkg::DIST_MASKED) ? rtmp_pkg::AGE_BAD
                                                           : rtmp_pkg::AGE_GOOD;
                push(rtmp_pkg::KIND_ADD, t.lo, hi, t.rnet, t.rnode, t.fin);
            end
        endfunction

        function void note_tick();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!used[i]) continue;
                case (tbl[i].age)
                    rtmp_pkg::AGE_GOOD: if (tbl[i].hops != 0) tbl[i].age = rtmp_pkg::AGE_SUSP;
                    rtmp_pkg::AGE_SUSP: tbl[i].age = rtmp_pkg::AGE_BAD;
                    rtmp_pkg::AGE_BAD:  tbl[i].age = rtmp_pkg::AGE_BAD2;
                    default: begin
                        used[i] = 0;
                        if (n < rtmp_pkg::RESULT_CAP) begin
                            push(rtmp_pkg::KIND_DEL, tbl[i].rt_start, tbl[i].rt_end,
                                 tbl[i].rnet, tbl[i].rnode, 1'b0);
                            n++;
                        end
                    end
                endcase
            end
            if (n == 0) push(rtmp_pkg::KIND_NONE, '0, '0, '0, '0, 1'b0);
        endfunction

        function void note_input(t_tuple t);
            if (t.op == OP_UPDATE) note_update(t);
            else note_tick();
            pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_result(rtmp_pkg::t_result got);
            rtmp_pkg::t_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_in_valid, i_out_ready;
    logic        o_in_ready, o_out_valid;
    logic        i_opcode, i_final_tuple;
    logic [15:0] i_range_start, i_range_end, i_router_net;
    logic [7:0]  i_tuple_info, i_router_node;
    logic [1:0]  o_notify_kind;
    logic [15:0] o_route_start, o_route_end, o_via_net;
    logic [7:0]  o_via_node;
    logic        o_packet_done, o_last;

    route_scoreboard sb;
    longint cycles;

    rtmp_route_table_unit u_dut (.*);

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: stall pattern, result sampling
    int stall_mode;
    always @(posedge i_clk) begin
        rtmp_pkg::t_result r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.kind = o_notify_kind; r.rt_start = o_route_start; r.rt_end = o_route_end;
            r.rnet = o_via_net; r.rnode = o_via_node; r.done = o_packet_done; r.last = o_last;
            sb.check_result(r);
        end
        if ((cycles % 500) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ((cycles % 7) < 2);
        endcase
    end

    task automatic send(t_tuple t);
        i_in_valid <= 1'b1;
        i_opcode <= t.op; i_range_start <= t.lo; i_range_end <= t.hi;
        i_tuple_info <= t.info; i_router_net <= t.rnet; i_router_node <= t.rnode;
        i_final_tuple <= t.fin;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(t);
    endtask

    task automatic idle(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_tuple upd(logic [15:0] lo, logic [15:0] hi, logic [7:0] info,
                                   logic [15:0] rn, logic [7:0] nd, logic fin);
        t_tuple t;
        t.op = OP_UPDATE; t.lo = lo; t.hi = hi; t.info = info;
        t.rnet = rn; t.rnode = nd; t.fin = fin;
        return t;
    endfunction

    function automatic t_tuple tick();
        t_tuple t;
        t = upd(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                1'($urandom));
        t.op = OP_TICK;
        return t;
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // random tuple drawn mostly from a small pool of ranges and routers
    function automatic t_tuple rand_update();
        logic [15:0] lo;
        logic [7:0]  info;
        lo = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 39) * 16);
        info = {1'($urandom_range(0, 1)), 2'($urandom), 5'($urandom_range(0, 31))};
        if ($urandom_range(0, 5) == 0) info[4:0] = rtmp_pkg::DIST_MASKED;
        return upd(lo, info[7] ? lo + 16'd7 : 16'($urandom), info,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3)),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2)),
                   1'($urandom));
    endfunction

    initial begin
        int burst;
        sb = new();
        cycles = 0; stall_mode = 0;
        i_rst_n <= 1'b0; i_in_valid <= 1'b0; i_out_ready <= 1'b0;
        i_opcode <= 1'b0; i_range_start <= '0; i_range_end <= '0; i_tuple_info <= '0;
        i_router_net <= '0; i_router_node <= '0; i_final_tuple <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send(tick());
        send(upd(16'h0000, 16'hffff, 8'h00, 16'h0000, 8'h00, 1'b0));
        send(upd(16'hffff, 16'h0000, 8'hff, 16'hffff, 8'hff, 1'b1));
        send(upd(16'h0010, 16'h0013, 8'h85, 16'h0001, 8'h01, 1'b0));
        send(upd(16'h0010, 16'h0013, 8'h82, 16'h0002, 8'h02, 1'b1));
        send(upd(16'h0010, 16'h0013, 8'h83, 16'h0003, 8'h03, 1'b0));
        send(upd(16'h0010, 16'h0013, 8'h88, 16'h0002, 8'h02, 1'b0));
        send(upd(16'h0010, 16'h0013, 8'h9f, 16'h0002, 8'h02, 1'b0));
        send(upd(16'h0010, 16'h0013, 8'h8e, 16'h0005, 8'h05, 1'b1));
        send(upd(16'h0010, 16'h0013, 8'h8f, 16'h0005, 8'h05, 1'b0));
        send(upd(16'h0020, 16'h1234, 8'h04, 16'h0007, 8'h07, 1'b0));
        send(upd(16'h0020, 16'h0000, 8'h1e, 16'h0007, 8'h07, 1'b1));
        send(upd(16'h0030, 16'h0000, 8'h1f, 16'h0009, 8'h09, 1'b0));
        send(upd(16'h0030, 16'h0000, 8'h0e, 16'h0008, 8'h08, 1'b0));
        for (int i = 0; i < 4; i++) send(tick());
        drain();
        // fill the table, drop, then two ticks, the second of which deletes many entries
        for (int i = 0; i < SLOTS + 2; i++)
            send(upd(16'(16'h0100 + i), 16'h0000, 8'h1f, 16'h00aa, 8'h0a, 1'($urandom)));
        send(tick());
        send(tick());
        drain();

        // random
        for (int n = 0; n < 150; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 150; b++, n++)
                send(($urandom_range(0, 7) == 0) ? tick() : rand_update());
            if (n > 100 && n < 115) drain();
            else idle($urandom_range(0, 1) ? 0 : $urandom_range(1, 60));
        end
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/rtmp_pkg.sv
hw/rtl/rtmp_ram.sv
hw/rtl/rtmp_route_table_unit.sv
tb/tb_rtmp_route_table_unit.sv
